@@ src/free_list_suballocator_defines.svh @@
// Assertion macros used by the checker file.
`ifndef FREE_LIST_SUBALLOCATOR_DEFINES_SVH
`define FREE_LIST_SUBALLOCATOR_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define FLS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated off during reset.
`define FLS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/fls_pkg.sv @@
// Types and constants of the free-list suballocator.
`timescale 1ns / 1ps

package fls_pkg;

	localparam int MAX_EXTENTS = 16;
	localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
	localparam int ADDR_W      = 3;

	localparam logic [ADDR_W-3:0] REG_POOL_BYTES = '0;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_NOFIT = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// One list entry as handed from a cell to its upper neighbor.
	typedef struct packed {
		logic        valid;
		logic [31:0] start;
		logic [31:0] len;
	} cell_data_t;

	// Chain bits travelling from low index to high index.
	typedef struct packed {
		logic passed;   // some lower cell is at or past the freed end
		logic shift;    // an insert happened below, move entries up
	} link_up_t;

	// Broadcast control from the top level to every cell.
	typedef struct packed {
		logic        seed;
		logic        capture;
		logic        update;
		op_t         op;
		logic        full;
		logic        no_hit;
		logic [31:0] pool;
		logic [31:0] req;
		logic [31:0] roff;
		logic [31:0] in_req;
		logic [32:0] in_end;
	} ctl_t;

endpackage

@@ src/fls_ifs.sv @@
// Request and response channel interfaces of the suballocator.
`timescale 1ns / 1ps

interface fls_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] request_bytes;
	logic [31:0] release_offset;

	modport source (output valid, output op, output request_bytes, output release_offset,
		input ready);
	modport sink (input valid, input op, input request_bytes, input release_offset,
		output ready);
endinterface

interface fls_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] granted_offset;

	modport source (output valid, output status, output granted_offset, input ready);
	modport sink (input valid, input status, input granted_offset, output ready);
endinterface

@@ src/free_list_suballocator.sv @@
// Top level of the free-list suballocator: cell row, control and APB port.
`timescale 1ns / 1ps

// The free space of one pool is held as a row of MAX_EXTENTS cells, one
// extent (start, length) per cell in offset order, entry 0 at the bottom.
// A request is handled thus: at the input transfer each cell compares
// its extent against the request and latches its match flags; in the
// update state one-bit chains through the row pick the winning cell (the
// highest cell that fits for an allocate, the lowest cell at or past the
// freed end for a free), and the row grows an extent, shrinks one, or
// shifts up by one cell to open a slot, while the result is loaded into
// the output register. No new request is taken until that update is
// done, and the update is held until the output register has room, so a
// stalled response holds the input too. The input is taken while a
// finished result still waits.
// Allocate returns the extent start and moves the extent forward; a free
// that ends at an extent start grows that extent backward, otherwise it
// is inserted before the first later extent or appended at the back. A
// full list gives status 2 for an insert or append and changes nothing.
// Register pool_bytes sits at APB byte address 0; writing it re-seeds the
// list with one extent [0, pool_bytes). Write it only while no request is
// in flight.
module free_list_suballocator (
	input  logic                        clk,
	input  logic                        arst_n,
	fls_req_if.sink                     req,
	fls_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fls_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int N = fls_pkg::MAX_EXTENTS;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_UPDATE = 2'b10
	} state_t;

	state_t state_q;

	logic [31:0]             pool_q;
	logic [fls_pkg::CNT_W-1:0] count_q;
	fls_pkg::op_t            op_s1;
	logic [31:0]             req_s1;
	logic [31:0]             roff_s1;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_granted_q;

	logic cfg_wr;
	logic in_xfer;
	logic fire;
	logic full;
	logic no_hit;
	logic grow_any;
	logic [31:0] grant_any;

	fls_pkg::ctl_t       ctl;
	fls_pkg::cell_data_t cdata [N];
	fls_pkg::link_up_t   up    [N+1];
	logic                above [N+1];
	logic                grow  [N];
	logic [31:0]         grant [N];

	// APB: always ready, one register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[fls_pkg::ADDR_W-1:2] == fls_pkg::REG_POOL_BYTES);
	assign prdata = (paddr[fls_pkg::ADDR_W-1:2] == fls_pkg::REG_POOL_BYTES) ? pool_q : 32'd0;

	// Request channel: take a request whenever no update is pending.
	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer   = req.valid && req.ready;

	// Update once the output register can take the result.
	assign fire = (state_q == ST_UPDATE) && (!out_valid_q || rsp.ready);
	assign full = (count_q == fls_pkg::CNT_W'(N));

	assign ctl.seed    = cfg_wr;
	assign ctl.capture = in_xfer;
	assign ctl.update  = fire;
	assign ctl.op      = op_s1;
	assign ctl.full    = full;
	assign ctl.no_hit  = no_hit;
	assign ctl.pool    = pwdata;
	assign ctl.req     = req_s1;
	assign ctl.roff    = roff_s1;
	assign ctl.in_req  = req.request_bytes;
	assign ctl.in_end  = {1'b0, req.release_offset} + {1'b0, req.request_bytes};

	// Chain ends: nothing below cell 0 for the free walk, nothing above the top cell.
	assign up[0]    = '0;
	assign above[N] = 1'b0;
	assign no_hit   = !up[N].passed;

	generate
		for (genvar g = 0; g < N; g++) begin : g_cell
			fls_pkg::cell_data_t prev;
			if (g == 0) begin : g_head
				assign prev = '{valid: 1'b1, start: 32'd0, len: 32'd0};
			end else begin : g_body
				assign prev = cdata[g-1];
			end
			fls_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.head     (g == 0),
				.ctl      (ctl),
				.prev_data(prev),
				.up_in    (up[g]),
				.above_in (above[g+1]),
				.data     (cdata[g]),
				.up_out   (up[g+1]),
				.above_out(above[g]),
				.grow     (grow[g]),
				.grant    (grant[g])
			);
		end
	endgenerate

	// At most one cell wins, so an OR collects its start.
	always_comb begin
		grow_any  = 1'b0;
		grant_any = 32'd0;
		for (int i = 0; i < N; i++) begin
			grow_any  = grow_any | grow[i];
			grant_any = grant_any | grant[i];
		end
	end

	// Hold the request fields for the update cycle.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= fls_pkg::op_t'(req.op);
			req_s1  <= req.request_bytes;
			roff_s1 <= req.release_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= 32'd0;
			count_q <= fls_pkg::CNT_W'(1);
		end else if (cfg_wr) begin
			pool_q  <= pwdata;
			count_q <= fls_pkg::CNT_W'(1);
		end else if (fire && (op_s1 == fls_pkg::OP_FREE) && !grow_any && !full) begin
			count_q <= count_q + fls_pkg::CNT_W'(1);
		end
	end

	// Output register: load on update, drop on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (op_s1 == fls_pkg::OP_ALLOC) begin
				out_status_q  <= above[0] ? fls_pkg::STATUS_OK : fls_pkg::STATUS_NOFIT;
				out_granted_q <= grant_any;
			end else begin
				out_status_q  <= (!grow_any && full) ? fls_pkg::STATUS_FULL
					: fls_pkg::STATUS_OK;
				out_granted_q <= 32'd0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.granted_offset = out_granted_q;

endmodule

@@ src/fls_cell.sv @@
// One free-list entry cell with its match flags and neighbor hand-off.
`timescale 1ns / 1ps

module fls_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head,
	input  fls_pkg::ctl_t      ctl,
	input  fls_pkg::cell_data_t prev_data,
	input  fls_pkg::link_up_t  up_in,
	input  logic               above_in,
	output fls_pkg::cell_data_t data,
	output fls_pkg::link_up_t  up_out,
	output logic               above_out,
	output logic               grow,
	output logic [31:0]        grant
);

	logic        valid_q;
	logic [31:0] start_q;
	logic [31:0] len_q;
	logic        fit_q;
	logic        lt_q;
	logic        eq_q;

	logic win;
	logic first;
	logic place_new;

	assign win       = fit_q && !above_in;
	assign first     = (lt_q || eq_q) && !up_in.passed;
	assign grow      = ctl.update && (ctl.op == fls_pkg::OP_FREE) && first && eq_q;
	assign place_new = (first && lt_q) || (ctl.no_hit && prev_data.valid && !valid_q);

	assign above_out     = above_in || fit_q;
	assign up_out.passed = up_in.passed || lt_q || eq_q;
	assign up_out.shift  = up_in.shift || (first && lt_q);

	assign data.valid = valid_q;
	assign data.start = start_q;
	assign data.len   = len_q;
	assign grant      = win ? start_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= head;
			start_q <= 32'd0;
			len_q   <= 32'd0;
			fit_q   <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else if (ctl.seed) begin
			valid_q <= head;
			if (head) begin
				start_q <= 32'd0;
				len_q   <= ctl.pool;
			end
		end else if (ctl.capture) begin
			fit_q <= valid_q && (len_q >= ctl.in_req);
			lt_q  <= valid_q && ({1'b0, start_q} > ctl.in_end);
			eq_q  <= valid_q && ({1'b0, start_q} == ctl.in_end);
		end else if (ctl.update) begin
			if (ctl.op == fls_pkg::OP_ALLOC) begin
				if (win) begin
					start_q <= start_q + ctl.req;
					len_q   <= len_q - ctl.req;
				end
			end else if (first && eq_q) begin
				start_q <= start_q - ctl.req;
				len_q   <= len_q + ctl.req;
			end else if (!ctl.full) begin
				if (place_new) begin
					valid_q <= 1'b1;
					start_q <= ctl.roff;
					len_q   <= ctl.req;
				end else if (up_in.shift) begin
					valid_q <= prev_data.valid;
					start_q <= prev_data.start;
					len_q   <= prev_data.len;
				end
			end
		end
	end

endmodule

@@ src/fls_checker.sv @@
// Port-level checks of the free-list suballocator and their bind.
`timescale 1ns / 1ps
`include "free_list_suballocator_defines.svh"

module fls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_status,
	input logic [31:0] out_granted
);

	// A request occupies the block for its update cycle.
	`FLS_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready, "ready after take")

	// A stalled response holds.
	`FLS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_granted), "response changed under stall")

	// Only a good allocation carries an offset.
	`FLS_ASSERT_NOW(a_grant_zero, clk, arst_n, out_valid && (out_status != fls_pkg::STATUS_OK), out_granted == 32'd0, "offset on failed result")

	// Nothing beyond the list-full code is ever produced.
	`FLS_ASSERT_NOW(a_status_code, clk, arst_n, out_valid, out_status <= fls_pkg::STATUS_FULL, "bad status code")

endmodule

bind free_list_suballocator fls_checker u_fls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_status (rsp.status),
	.out_granted(rsp.granted_offset)
);

@@ verif/free_list_suballocator_tb.sv @@
// Self-checking testbench of the free-list suballocator.
`timescale 1ns / 1ps

// Drive requests through the request channel and hold a shadow copy of the
// free list: every accepted request is applied to that copy at its transfer
// edge, and the outcome it yields (status, granted offset) is queued in
// order. Check each response transfer against the oldest queued outcome.
// Rewrite pool_bytes over the APB port only once the queue is empty and the
// row has had time to settle, since a re-seed clears the whole list.
// The stimulus opens with directed requests on the reset list and on a small
// pool, then runs rounds of random traffic. Each round re-seeds the pool.
// Most requests in a round are well formed: allocates of sizes that fit the
// pool and frees of ranges granted earlier. The rest is noise: random fields,
// small frees inside the pool, or zero-byte allocates. Both channel sides idle
// at random, with some rounds run back to back on one side or both.
module free_list_suballocator_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int ROUNDS       = 12;
	localparam int ROUND_ITEMS  = 50;
	localparam int MAX_IDLE     = 12;

	// Index past the last register; a write there must leave the list alone.
	localparam logic [fls_pkg::ADDR_W-3:0] REG_UNUSED = 1'b1;

	typedef struct packed {
		fls_pkg::status_t status;
		logic [31:0]      offset;
	} outcome_t;

	typedef struct {
		logic [31:0] offset;
		logic [31:0] size;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [fls_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fls_req_if req_ch ();
	fls_rsp_if rsp_ch ();

	free_list_suballocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// Shadow free list, kept in the same order as the cell row.
	logic [31:0] free_start [fls_pkg::MAX_EXTENTS];
	logic [31:0] free_len   [fls_pkg::MAX_EXTENTS];
	int          free_count;

	outcome_t pending_results [$];
	grant_t   live_grants [$];

	bit send_quiet;
	bit recv_quiet;

	int cycle_count;
	int mismatch_count;
	int allocs_sent;
	int frees_sent;
	int pool_settings;
	int ok_seen;
	int nofit_seen;
	int full_seen;

	function automatic void reseed_free_list(logic [31:0] pool);
		for (int k = 0; k < fls_pkg::MAX_EXTENTS; k++) begin
			free_start[k] = '0;
			free_len[k]   = '0;
		end
		free_len[0] = pool;
		free_count  = 1;
	endfunction

	// Open a slot at pos by moving the entries above it up one cell, unless the list is full.
	function automatic fls_pkg::status_t insert_extent(int pos, logic [31:0] start,
			logic [31:0] length);
		if (free_count >= fls_pkg::MAX_EXTENTS)
			return fls_pkg::STATUS_FULL;
		for (int j = free_count; j > pos; j--) begin
			free_start[j] = free_start[j-1];
			free_len[j]   = free_len[j-1];
		end
		free_start[pos] = start;
		free_len[pos]   = length;
		free_count++;
		return fls_pkg::STATUS_OK;
	endfunction

	function automatic outcome_t predict_request(fls_pkg::op_t op, logic [31:0] nbytes,
			logic [31:0] offset);
		outcome_t   res;
		logic [32:0] range_end;
		bit         done;
		res.status = fls_pkg::STATUS_OK;
		res.offset = '0;
		done       = 1'b0;
		if (op == fls_pkg::OP_ALLOC) begin
			// Take the highest extent that fits; start wraps modulo 2^32.
			res.status = fls_pkg::STATUS_NOFIT;
			for (int k = free_count - 1; k >= 0 && !done; k--) begin
				if (free_len[k] >= nbytes) begin
					res.offset    = free_start[k];
					free_start[k] = free_start[k] + nbytes;
					free_len[k]   = free_len[k] - nbytes;
					res.status    = fls_pkg::STATUS_OK;
					done          = 1'b1;
				end
			end
		end else begin
			// Form the end in 33 bits; an end at or past 2^32 matches nothing.
			range_end = {1'b0, offset} + {1'b0, nbytes};
			for (int k = 0; k < free_count && !done; k++) begin
				if (range_end < {1'b0, free_start[k]}) begin
					res.status = insert_extent(k, offset, nbytes);
					done       = 1'b1;
				end else if (range_end == {1'b0, free_start[k]}) begin
					free_start[k] = free_start[k] - nbytes;
					free_len[k]   = free_len[k] + nbytes;
					done          = 1'b1;
				end
			end
			if (!done)
				res.status = insert_extent(free_count, offset, nbytes);
		end
		return res;
	endfunction

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
	endfunction

	// Present one request after a random gap and hold it until its transfer.
	task automatic send_request(input fls_pkg::op_t op, input logic [31:0] nbytes,
			input logic [31:0] offset, output outcome_t res);
		int gap;
		gap = draw_wait(send_quiet);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid          = 1'b1;
		req_ch.op             = op;
		req_ch.request_bytes  = nbytes;
		req_ch.release_offset = offset;
		do @(posedge clk); while (!req_ch.ready);
		res = predict_request(op, nbytes, offset);
		pending_results.insert(pending_results.size(), res);
		if (op == fls_pkg::OP_ALLOC)
			allocs_sent++;
		else
			frees_sent++;
	endtask

	// Drop valid, wait out every outstanding response, then let the row settle.
	task automatic wait_all_results();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the data at the edge
	// that closes the access cycle. Read pool_bytes back afterwards.
	task automatic apb_write(input logic [fls_pkg::ADDR_W-3:0] index,
			input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {index, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (index == fls_pkg::REG_POOL_BYTES) begin
			reseed_free_list(value);
			live_grants.delete();
			pool_settings++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (index == fls_pkg::REG_POOL_BYTES && prdata !== value) begin
			$error("prdata: expected 0x%08h, got 0x%08h", value, prdata);
			mismatch_count++;
		end
	endtask

	// Reset list is one exhausted extent at 0; build on it without a re-seed.
	task automatic test_reset_state();
		outcome_t res;
		send_request(fls_pkg::OP_ALLOC, 32'd0, 32'd0, res);   // zero bytes on empty extent
		send_request(fls_pkg::OP_ALLOC, 32'd1, 32'd0, res);   // no fit
		send_request(fls_pkg::OP_FREE, 32'hFFFF_FFF0, 32'h1000, res); // end past 2^32
		send_request(fls_pkg::OP_FREE, 32'h800, 32'h800, res); // grow back, length wraps
		send_request(fls_pkg::OP_ALLOC, 32'h7F0, 32'hFFFF_FFFF, res);
		send_request(fls_pkg::OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, res);
		send_request(fls_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0, res); // start wraps around
		send_request(fls_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0, res); // no fit
	endtask

	task automatic test_basic_operations();
		outcome_t res;
		wait_all_results();
		apb_write(fls_pkg::REG_POOL_BYTES, 32'h1000);
		send_request(fls_pkg::OP_ALLOC, 32'h100, 32'd0, res);
		send_request(fls_pkg::OP_ALLOC, 32'd0, 32'd0, res);
		send_request(fls_pkg::OP_ALLOC, 32'h2000, 32'd0, res);
		send_request(fls_pkg::OP_FREE, 32'h100, 32'd0, res);    // grows the extent back to 0
		send_request(fls_pkg::OP_FREE, 32'h10, 32'h2000, res);  // past every extent, append
		send_request(fls_pkg::OP_ALLOC, 32'h10, 32'd0, res);    // exhausts the last extent
		send_request(fls_pkg::OP_ALLOC, 32'd0, 32'd0, res);     // exhausted extent still taken
		send_request(fls_pkg::OP_FREE, 32'h100, 32'h1800, res); // insert between extents
		send_request(fls_pkg::OP_ALLOC, 32'h1000, 32'd0, res);
	endtask

	task automatic test_unused_register();
		outcome_t res;
		wait_all_results();
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		send_request(fls_pkg::OP_ALLOC, 32'd1, 32'd0, res);
		send_request(fls_pkg::OP_ALLOC, 32'd0, 32'd0, res);
	endtask

	function automatic logic [31:0] pick_pool(int round);
		case (round)
			0: return 32'hFFFF_FFFF;
			1: return 32'd0;
			default: begin
				case ($urandom_range(0, 3))
					0: return $urandom_range(16, 256);
					1: return $urandom_range(256, 65536);
					2: return $urandom;
					default: return 32'hFFFF_FFFF - $urandom_range(0, 255);
				endcase
			end
		endcase
	endfunction

	task automatic test_random_traffic();
		outcome_t    res;
		logic [31:0] pool;
		logic [31:0] nbytes;
		grant_t      g;
		int          idx;
		int          pick;
		for (int r = 0; r < ROUNDS; r++) begin
			wait_all_results();
			pool = pick_pool(r);
			apb_write(fls_pkg::REG_POOL_BYTES, pool);
			send_quiet = (r % 4 == 1) || (r % 4 == 3);
			recv_quiet = (r % 4 == 2) || (r % 4 == 3);
			for (int n = 0; n < ROUND_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					nbytes = ($urandom_range(0, 15) == 0) ? 32'd0
						: $urandom_range(1, (pool >> 3) + 32'd1);
					send_request(fls_pkg::OP_ALLOC, nbytes, $urandom, res);
					if (res.status == fls_pkg::STATUS_OK) begin
						g.offset = res.offset;
						g.size   = nbytes;
						live_grants.insert(live_grants.size(), g);
					end
				end else if (pick < 80 && live_grants.size() != 0) begin
					idx = $urandom_range(0, live_grants.size() - 1);
					g   = live_grants[idx];
					live_grants.delete(idx);
					send_request(fls_pkg::OP_FREE, g.size, g.offset, res);
				end else begin
					case ($urandom_range(0, 3))
						0: send_request(fls_pkg::OP_ALLOC, $urandom, $urandom, res);
						1: send_request(fls_pkg::OP_FREE, $urandom, $urandom, res);
						2: send_request(fls_pkg::OP_FREE, $urandom_range(0, 64),
							$urandom_range(0, pool), res);
						default: send_request(fls_pkg::OP_ALLOC, 32'd0, $urandom, res);
					endcase
				end
				// Hold the sender until the pipe is empty, once for sure, else rarely.
				if ((r == 2 && n == ROUND_ITEMS / 2) || $urandom_range(0, 49) == 0)
					wait_all_results();
			end
		end
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	// Response side: stall a random number of cycles before each transfer.
	initial begin : rsp_ready_driver
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(recv_quiet);
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Compare every response transfer with the oldest queued outcome.
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("response transfer with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				case (want.status)
					fls_pkg::STATUS_OK:    ok_seen++;
					fls_pkg::STATUS_NOFIT: nofit_seen++;
					default:               full_seen++;
				endcase
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					mismatch_count++;
				end
				if (rsp_ch.granted_offset !== want.offset) begin
					$error("granted_offset: expected 0x%08h, got 0x%08h",
						want.offset, rsp_ch.granted_offset);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		req_ch.valid          = 1'b0;
		req_ch.op             = fls_pkg::OP_ALLOC;
		req_ch.request_bytes  = '0;
		req_ch.release_offset = '0;
		rsp_ch.ready          = 1'b0;
		send_quiet            = 1'b0;
		recv_quiet            = 1'b0;
		reseed_free_list(32'd0);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_basic_operations();
		test_unused_register();
		test_random_traffic();
		wait_all_results();

		$display("Sent %0d allocates and %0d frees across %0d pool settings.",
			allocs_sent, frees_sent, pool_settings);
		$display("Responses: %0d ok, %0d no-fit, %0d list-full; %0d mismatches.",
			ok_seen, nofit_seen, full_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ free_list_suballocator.f @@
+incdir+src
src/fls_pkg.sv
src/fls_ifs.sv
src/fls_cell.sv
src/free_list_suballocator.sv
src/fls_checker.sv
verif/free_list_suballocator_tb.sv
